// File: hw/rtl/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types, screen geometry and the 5x7 font table of the glyph renderer.
// ----------------------------------------------------------------------------
package gfr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int IDX_W         = 13;

  // last glyph column and last drawn glyph row (bit 7 of a column is never drawn)
  localparam logic [2:0] GLYPH_COL_LAST = 3'd4;
  localparam logic [2:0] GLYPH_ROW_LAST = 3'd6;
  localparam logic [2:0] PIXEL_ROW_LAST = 3'd0;

  // glyph drawn for codes outside the font range
  localparam logic [39:0] FALLBACK_GLYPH = 40'h0201590906;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_CHAR  = 2'd2,
    OP_READ  = 2'd3
  } gfr_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_READ
  } gfr_state_t;

  // five glyph columns, leftmost column in bits 39:32
  function automatic logic [39:0] glyph_cols(input logic [7:0] code);
    logic [39:0] g;
    unique case (code)
      8'd32:   g = 40'h0000000000;
      8'd33:   g = 40'h00005F0000;
      8'd34:   g = 40'h0007000700;
      8'd35:   g = 40'h147F147F14;
      8'd36:   g = 40'h242A7F2A12;
      8'd37:   g = 40'h2313086462;
      8'd38:   g = 40'h3649562050;
      8'd39:   g = 40'h0008070300;
      8'd40:   g = 40'h001C224100;
      8'd41:   g = 40'h0041221C00;
      8'd42:   g = 40'h2A1C7F1C2A;
      8'd43:   g = 40'h08083E0808;
      8'd44:   g = 40'h0080703000;
      8'd45:   g = 40'h0808080808;
      8'd46:   g = 40'h0000606000;
      8'd47:   g = 40'h2010080402;
      8'd48:   g = 40'h3E5149453E;
      8'd49:   g = 40'h00427F4000;
      8'd50:   g = 40'h7249494946;
      8'd51:   g = 40'h2141494D33;
      8'd52:   g = 40'h1814127F10;
      8'd53:   g = 40'h2745454539;
      8'd54:   g = 40'h3C4A494931;
      8'd55:   g = 40'h4121110907;
      8'd56:   g = 40'h3649494936;
      8'd57:   g = 40'h464949291E;
      8'd58:   g = 40'h0000140000;
      8'd59:   g = 40'h0040340000;
      8'd60:   g = 40'h0008142241;
      8'd61:   g = 40'h1414141414;
      8'd62:   g = 40'h0041221408;
      8'd63:   g = 40'h0201590906;
      8'd64:   g = 40'h3E415D594E;
      8'd65:   g = 40'h7C1211127C;
      8'd66:   g = 40'h7F49494936;
      8'd67:   g = 40'h3E41414122;
      8'd68:   g = 40'h7F4141413E;
      8'd69:   g = 40'h7F49494941;
      8'd70:   g = 40'h7F09090901;
      8'd71:   g = 40'h3E41415173;
      8'd72:   g = 40'h7F0808087F;
      8'd73:   g = 40'h00417F4100;
      8'd74:   g = 40'h2040413F01;
      8'd75:   g = 40'h7F08142241;
      8'd76:   g = 40'h7F40404040;
      8'd77:   g = 40'h7F021C027F;
      8'd78:   g = 40'h7F0408107F;
      8'd79:   g = 40'h3E4141413E;
      8'd80:   g = 40'h7F09090906;
      8'd81:   g = 40'h3E4151215E;
      8'd82:   g = 40'h7F09192946;
      8'd83:   g = 40'h2649494932;
      8'd84:   g = 40'h03017F0103;
      8'd85:   g = 40'h3F4040403F;
      8'd86:   g = 40'h1F2040201F;
      8'd87:   g = 40'h3F4038403F;
      8'd88:   g = 40'h6314081463;
      8'd89:   g = 40'h0304780403;
      8'd90:   g = 40'h6159494D43;
      default: g = FALLBACK_GLYPH;
    endcase
    return g;
  endfunction

endpackage

// File: hw/rtl/gfr_ram.sv
// ----------------------------------------------------------------------------
// gfr_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/glyph_framebuffer_renderer_core.sv
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer_core
// Page-organized monochrome frame store with a 5x7 character generator.
// ----------------------------------------------------------------------------
// usage
//   command channel: an item (op, pos_x, pos_y, pixel_on, char_code,
//   read_index) is taken at a rising edge with start high and busy low.
//   ops: clear all, draw one pixel, draw one 5x7 character, read one byte.
//   pixel (x, y) sits in byte x + (y/8)*SCREEN_WIDTH at bit y%8.
//   result channel: only a read gives a result; done is high for exactly one
//   cycle, in the cycle after the read is taken, with read_data valid alongside.
//   the receiver cannot stall, so results never back up.
// steps (drawing is read-modify-write on the one frame store RAM port pair)
//   read  : busy in ST_READ, which gives the result
//   pixel : fetch, modify
//   char  : 5 columns x 2 pages x (fetch, modify)
//   clear : all 1024 bytes, one byte written per cycle
// reset
//   rst starts a clearing pass over all 1024 bytes; busy stays high for the
//   whole pass and no item is taken meanwhile
// ----------------------------------------------------------------------------
module glyph_framebuffer_renderer_core
  import gfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic signed [8:0] pos_x,
  input  logic signed [7:0] pos_y,
  input  logic              pixel_on,
  input  logic [7:0]        char_code,
  input  logic [9:0]        read_index,
  output logic              done,
  output logic [7:0]        read_data
);

  localparam logic signed [10:0] X_LIMIT = 11'(SCREEN_WIDTH);
  localparam logic signed [10:0] Y_LIMIT = 11'(SCREEN_HEIGHT);

  gfr_state_t state, state_next;

  // clear sweep address
  logic [ADDR_W-1:0] clr_cnt;

  // current drawing job
  logic signed [8:0] base_x;
  logic signed [7:0] base_y;
  logic [2:0]        col_idx;
  logic              pass;
  logic [2:0]        last_row;
  logic              is_pixel;
  logic [39:0]       glyph_q;   // current column in bits 39:32, shifts left per column

  // byte under modification
  logic [ADDR_W-1:0] idx_q;
  logic              hit_q;
  logic [7:0]        mask_q;
  logic [7:0]        val_q;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // per-byte address and mask computation
  logic signed [10:0] cur_x;
  logic signed [5:0]  cur_pg;
  logic               x_ok;
  logic signed [10:0] row_abs [8];
  logic signed [10:0] glyph_row [8];
  logic signed [10:0] row_max;
  logic [7:0]         mask_calc;
  logic [7:0]         val_calc;
  logic [IDX_W-1:0]   idx_full;
  logic               hit_calc;
  logic               job_last;
  logic               accept;

  assign accept   = start && !busy;
  assign job_last = is_pixel || ((col_idx == GLYPH_COL_LAST) && pass);

  always_comb begin
    cur_x   = 11'(base_x) + 11'(col_idx);
    // glyph spans its top page and the one below it
    cur_pg  = 6'(base_y >>> 3) + 6'(pass);
    x_ok    = (cur_x >= 0) && (cur_x < X_LIMIT);
    row_max = {8'b0, last_row};
    for (int r = 0; r < 8; r++) begin
      row_abs[r]   = {cur_pg[5], cur_pg[5], cur_pg, 3'(r)};
      glyph_row[r] = row_abs[r] - 11'(base_y);
      mask_calc[r] = x_ok && (glyph_row[r] >= 0) && (glyph_row[r] <= row_max)
                     && (row_abs[r] >= 0) && (row_abs[r] < Y_LIMIT);
      // bit 32 + row of the current column
      val_calc[r]  = glyph_q[{3'b100, glyph_row[r][2:0]}];
    end
    idx_full = IDX_W'(cur_x[7:0]) + IDX_W'(cur_pg[3:0]) * IDX_W'(SCREEN_WIDTH);
    hit_calc = (|mask_calc) && (idx_full < IDX_W'(STORE_DEPTH));
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, handshake and ram control
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = (ram_rdata & ~mask_q) | (val_q & mask_q);
    ram_raddr  = idx_full[ADDR_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy      = 1'b0;
        ram_raddr = read_index;
        if (start) begin
          unique case (gfr_op_t'(op))
            OP_CLEAR: state_next = ST_CLEAR;
            OP_PIXEL: state_next = ST_FETCH;
            OP_CHAR:  state_next = ST_FETCH;
            OP_READ:  state_next = ST_READ;
          endcase
        end
      end
      ST_FETCH: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        ram_we = hit_q;
        if (job_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_READ: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign read_data = ram_rdata;

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end else begin
      clr_cnt <= '0;
    end
  end

  // job registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      pass     <= 1'b0;
      is_pixel <= 1'b0;
    end else if (accept) begin
      base_x  <= pos_x;
      base_y  <= pos_y;
      col_idx <= '0;
      pass    <= 1'b0;
      if (gfr_op_t'(op) == OP_PIXEL) begin
        is_pixel <= 1'b1;
        last_row <= PIXEL_ROW_LAST;
        glyph_q  <= {7'b0, pixel_on, 32'b0};
      end else begin
        is_pixel <= 1'b0;
        last_row <= GLYPH_ROW_LAST;
        glyph_q  <= glyph_cols(char_code);
      end
    end else if (state == ST_MODIFY && !job_last) begin
      // walk both pages of a column, then move to the next column
      pass <= !pass;
      if (pass) begin
        col_idx <= col_idx + 1'b1;
        glyph_q <= {glyph_q[31:0], 8'b0};
      end
    end
  end

  // byte address and masks, captured while its read is in flight
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      idx_q  <= idx_full[ADDR_W-1:0];
      hit_q  <= hit_calc;
      mask_q <= mask_calc;
      val_q  <= val_calc;
    end
  end

  gfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a taken read gives its result in the very next cycle
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (gfr_op_t'(op) == OP_READ)) |=> done)
    else $error("read item without result");

  // results only follow a read item
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && (gfr_op_t'(op) == OP_READ)))
    else $error("result without a read item");

  // the store is never written while the block is idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ram_we)
    else $error("store written while idle");

  // a clearing pass runs to its last byte before anything else
  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_cnt != ADDR_W'(STORE_DEPTH - 1)) |=> (state == ST_CLEAR))
    else $error("clearing pass cut short");

endmodule
